### sv/kmst_pkg.sv
// kmst_pkg: shared types, key codes and the fixed keymap rom for the
// keymap sticky modifier translator. No dependencies; used by
// keymap_sticky_modifier_translator_top.
package kmst_pkg;

    // operation codes of an input transaction
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_POP   = 1'b1;

    // rom size; codes at or above this read the blank entry
    localparam int KEYMAP_ENTRIES = 65;

    // special and non-printing key codes
    localparam logic [7:0] K_SHIFT = 8'hE1;
    localparam logic [7:0] K_FN    = 8'h3A;
    localparam logic [7:0] K_FILE  = 8'h43;
    localparam logic [7:0] K_MENU  = 8'h44;
    localparam logic [7:0] K_RET   = 8'h28;
    localparam logic [7:0] K_ESC   = 8'h29;
    localparam logic [7:0] K_BSP   = 8'h2A;
    localparam logic [7:0] K_TAB   = 8'h2B;
    localparam logic [7:0] K_RGHT  = 8'h4F;
    localparam logic [7:0] K_LEFT  = 8'h50;
    localparam logic [7:0] K_DOWN  = 8'h51;
    localparam logic [7:0] K_UP    = 8'h52;
    localparam logic [7:0] K_PGUP  = 8'h4B;
    localparam logic [7:0] K_PGDN  = 8'h4E;
    localparam logic [7:0] K_HOME  = 8'h4A;
    localparam logic [7:0] K_END   = 8'h4D;
    localparam logic [7:0] K_POUND = 8'hA3;

    // modifier state: off, one-shot, locked
    typedef enum logic [1:0] {
        MOD_OFF     = 2'd0,
        MOD_ONESHOT = 2'd1,
        MOD_LOCKED  = 2'd2
    } mod_state_t;

    // menu state: off, on, sub/file
    typedef enum logic [1:0] {
        MENU_OFF = 2'd0,
        MENU_ON  = 2'd1,
        MENU_SUB = 2'd2
    } menu_state_t;

    // one keymap row
    typedef struct packed {
        logic [7:0] lower;
        logic [7:0] upper;
        logic [7:0] fn_val;
        logic       is_char;
    } keymap_entry_t;

    // queued translated key
    typedef struct packed {
        logic       is_char;
        logic [7:0] value;
    } queue_entry_t;

    function automatic keymap_entry_t mk(input logic [7:0] lo, input logic [7:0] up,
                                         input logic [7:0] fv, input logic ch);
        keymap_entry_t e;
        e.lower   = lo;
        e.upper   = up;
        e.fn_val  = fv;
        e.is_char = ch;
        return e;
    endfunction

    // fixed keymap; unlisted codes are blank
    function automatic keymap_entry_t keymap_lookup(input logic [6:0] code);
        keymap_entry_t e;
        case (code)
            7'd1:  e = mk(K_TAB, K_TAB, K_TAB, 1'b0);
            7'd2:  e = mk("q", "Q", "!", 1'b1);
            7'd3:  e = mk("w", "W", "\"", 1'b1);
            7'd4:  e = mk("e", "E", "@", 1'b1);
            7'd5:  e = mk("r", "R", K_POUND, 1'b1);
            7'd6:  e = mk("t", "T", "$", 1'b1);
            7'd7:  e = mk("y", "Y", "%", 1'b1);
            7'd8:  e = mk("u", "U", "^", 1'b1);
            7'd9:  e = mk("i", "I", "&", 1'b1);
            7'd11: e = mk(K_SHIFT, K_SHIFT, K_SHIFT, 1'b0);
            7'd12: e = mk("a", "A", "|", 1'b1);
            7'd13: e = mk("s", "S", "#", 1'b1);
            7'd14: e = mk("d", "D", ",", 1'b1);
            7'd15: e = mk("f", "F", "?", 1'b1);
            7'd16: e = mk("g", "G", "'", 1'b1);
            7'd17: e = mk("h", "H", ":", 1'b1);
            7'd18: e = mk("j", "J", ";", 1'b1);
            7'd19: e = mk("k", "K", "{", 1'b1);
            7'd21: e = mk(K_FN, K_FN, K_FN, 1'b0);
            7'd22: e = mk("z", "Z", " ", 1'b1);
            7'd23: e = mk("x", "X", "\\", 1'b1);
            7'd24: e = mk("c", "C", "~", 1'b1);
            7'd25: e = mk(" ", " ", " ", 1'b1);
            7'd26: e = mk(" ", " ", " ", 1'b1);
            7'd27: e = mk("v", "V", "<", 1'b1);
            7'd28: e = mk("b", "B", ">", 1'b1);
            7'd29: e = mk("n", "N", "[", 1'b1);
            7'd31: e = mk("=", "=", "=", 1'b1);
            7'd32: e = mk(".", ".", ".", 1'b1);
            7'd33: e = mk("0", "0", "0", 1'b1);
            7'd34: e = mk("+", "+", "+", 1'b1);
            7'd35: e = mk(K_UP, K_UP, K_PGUP, 1'b0);
            7'd36: e = mk(K_RGHT, K_RGHT, K_END, 1'b0);
            7'd37: e = mk(K_RET, K_RET, K_RET, 1'b0);
            7'd38: e = mk(K_RET, K_RET, K_RET, 1'b0);
            7'd39: e = mk("m", "M", "]", 1'b1);
            7'd41: e = mk("3", "3", "3", 1'b1);
            7'd42: e = mk("2", "2", "2", 1'b1);
            7'd43: e = mk("1", "1", "1", 1'b1);
            7'd44: e = mk("-", "-", "-", 1'b1);
            7'd45: e = mk(K_LEFT, K_LEFT, K_HOME, 1'b0);
            7'd46: e = mk(K_DOWN, K_DOWN, K_PGDN, 1'b0);
            7'd47: e = mk(K_ESC, K_ESC, K_ESC, 1'b0);
            7'd48: e = mk(K_RET, K_RET, K_RET, 1'b0);
            7'd49: e = mk("l", "L", "}", 1'b1);
            7'd51: e = mk("6", "6", "6", 1'b1);
            7'd52: e = mk("5", "5", "5", 1'b1);
            7'd53: e = mk("4", "4", "4", 1'b1);
            7'd54: e = mk("*", "*", "*", 1'b1);
            7'd55: e = mk(K_FILE, K_FILE, K_FILE, 1'b0);
            7'd56: e = mk(K_MENU, K_MENU, K_MENU, 1'b0);
            7'd57: e = mk(K_BSP, K_BSP, K_BSP, 1'b0);
            7'd58: e = mk("p", "P", "p", 1'b1);
            7'd59: e = mk("o", "O", "o", 1'b1);
            7'd61: e = mk("9", "9", "9", 1'b1);
            7'd62: e = mk("8", "8", "8", 1'b1);
            7'd63: e = mk("7", "7", "7", 1'b1);
            7'd64: e = mk("/", "/", "/", 1'b1);
            default: e = mk(8'h00, 8'h00, 8'h00, 1'b0);
        endcase
        return e;
    endfunction

    // off -> one-shot -> locked -> off
    function automatic mod_state_t mod_cycle(input mod_state_t s);
        mod_state_t n;
        case (s)
            MOD_OFF:     n = MOD_ONESHOT;
            MOD_ONESHOT: n = MOD_LOCKED;
            default:     n = MOD_OFF;
        endcase
        return n;
    endfunction

endpackage

### sv/keymap_sticky_modifier_translator_top.sv
// keymap_sticky_modifier_translator_top: keypad event translator with sticky
// shift/fn modifiers, menu state and a queue of translated keys.
// Depends on kmst_pkg (types, key codes, keymap rom).
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid, in_ready  | op, key_code, key_down
//  out     | out_valid, out_ready| key_value, is_char, pop_valid, refresh,
//          |                     | dropped, shift_mode, fn_mode, menu_mode,
//          |                     | queued_count
//
// One transaction per cycle: the rom lookup, modifier update and queue push or
// pop happen in the accept cycle and land in the result register in the next cycle.
// in_ready is high while the result register is empty or being taken, so a
// stalled output holds the input off; nothing else stalls.
// The queue memory read at the head pointer is registered at accept of a pop.
// Reset clears modifiers, menu state, queue pointers and output valid.
module keymap_sticky_modifier_translator_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [6:0] key_code,
    input  logic       key_down,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] key_value,
    output logic       is_char,
    output logic       pop_valid,
    output logic       refresh,
    output logic       dropped,
    output logic [1:0] shift_mode,
    output logic [1:0] fn_mode,
    output logic [1:0] menu_mode,
    output logic [4:0] queued_count
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    // state and result registers
    kmst_pkg::mod_state_t  shift_reg, shift_next;
    kmst_pkg::mod_state_t  fn_reg, fn_next;
    kmst_pkg::menu_state_t menu_reg, menu_next;
    logic [PW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  out_valid_reg;
    logic                  pop_valid_reg, pop_valid_next;
    logic                  refresh_reg, refresh_next;
    logic                  dropped_reg, dropped_next;
    kmst_pkg::queue_entry_t rd_reg;

    kmst_pkg::queue_entry_t queue_mem [QUEUE_DEPTH];

    logic                   accept;
    logic                   push;
    kmst_pkg::keymap_entry_t ent;
    logic [6:0]             rom_idx;
    logic [7:0]             tr_value;
    logic [SW-1:0]          tail_sum;
    logic [PW-1:0]          tail;
    logic                   queue_full;
    logic [31:0]            count_wide;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // rom lookup; out-of-table codes use the blank entry
    assign rom_idx    = (32'(key_code) < kmst_pkg::KEYMAP_ENTRIES) ? key_code : 7'd0;
    assign ent        = kmst_pkg::keymap_lookup(rom_idx);
    assign queue_full = (count_reg >= CW'(QUEUE_DEPTH));

    // tail pointer, sum stays below twice the depth
    always_comb
    begin
        tail_sum = SW'(head_reg) + SW'(count_reg);
        if (tail_sum >= SW'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - SW'(QUEUE_DEPTH);
        end
        tail = tail_sum[PW-1:0];
    end

    // next state for one transaction
    always_comb
    begin
        shift_next     = shift_reg;
        fn_next        = fn_reg;
        menu_next      = menu_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        pop_valid_next = 1'b0;
        refresh_next   = 1'b0;
        dropped_next   = 1'b0;
        push           = 1'b0;
        tr_value       = ent.lower;
        if (accept)
        begin
            case (op)
                kmst_pkg::OP_POP:
                begin
                    if (count_reg != '0)
                    begin
                        pop_valid_next = 1'b1;
                        head_next  = (head_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    if (key_down)
                    begin
                        refresh_next = 1'b1;
                        if (ent.lower == kmst_pkg::K_SHIFT)
                        begin
                            shift_next = kmst_pkg::mod_cycle(shift_reg);
                        end
                        else if (ent.lower == kmst_pkg::K_FN)
                        begin
                            fn_next = kmst_pkg::mod_cycle(fn_reg);
                        end
                        else if (ent.lower == kmst_pkg::K_MENU)
                        begin
                            menu_next = (menu_reg == kmst_pkg::MENU_ON) ?
                                        kmst_pkg::MENU_OFF : kmst_pkg::MENU_ON;
                        end
                        else if (ent.lower == kmst_pkg::K_FILE)
                        begin
                            // ignored while the menu is on
                            if (menu_reg == kmst_pkg::MENU_OFF)
                            begin
                                menu_next = kmst_pkg::MENU_SUB;
                            end
                            else if (menu_reg == kmst_pkg::MENU_SUB)
                            begin
                                menu_next = kmst_pkg::MENU_OFF;
                            end
                        end
                        else
                        begin
                            // fn layer over shift layer over lower
                            if (fn_reg != kmst_pkg::MOD_OFF)
                            begin
                                tr_value = ent.fn_val;
                                if (fn_reg == kmst_pkg::MOD_ONESHOT)
                                begin
                                    fn_next = kmst_pkg::MOD_OFF;
                                end
                            end
                            else if (shift_reg != kmst_pkg::MOD_OFF)
                            begin
                                tr_value = ent.upper;
                                if (shift_reg == kmst_pkg::MOD_ONESHOT)
                                begin
                                    shift_next = kmst_pkg::MOD_OFF;
                                end
                            end
                            if (queue_full)
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                push       = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= kmst_pkg::MOD_OFF;
            fn_reg        <= kmst_pkg::MOD_OFF;
            menu_reg      <= kmst_pkg::MENU_OFF;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pop_valid_reg <= 1'b0;
            refresh_reg   <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            fn_reg    <= fn_next;
            menu_reg  <= menu_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                pop_valid_reg <= pop_valid_next;
                refresh_reg   <= refresh_next;
                dropped_reg   <= dropped_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // queue memory: one write port at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[tail] <= '{is_char: ent.is_char, value: tr_value};
        end
        if (accept && (op == kmst_pkg::OP_POP))
        begin
            rd_reg <= queue_mem[head_reg];
        end
    end

    // result port
    assign count_wide   = 32'(count_reg);
    assign out_valid    = out_valid_reg;
    assign key_value    = pop_valid_reg ? rd_reg.value : 8'h00;
    assign is_char      = pop_valid_reg & rd_reg.is_char;
    assign pop_valid    = pop_valid_reg;
    assign refresh      = refresh_reg;
    assign dropped      = dropped_reg;
    assign shift_mode   = shift_reg;
    assign fn_mode      = fn_reg;
    assign menu_mode    = menu_reg;
    assign queued_count = count_wide[4:0];

endmodule
